FILE: rtl/ttlc_pkg.sv
// Shared types, command and status codes, and reset values for the TTL cache tag table.
package ttlc_pkg;

    // Default table depth and configuration reset values
    localparam int unsigned ENTRIES_DEF  = 16;
    localparam logic [31:0] TTL_RESET    = 32'd60;
    localparam logic [23:0] MAXLEN_RESET = 24'd1048576;

    // Command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_SAVE   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_MISS            = 3'd0;
    localparam logic [2:0] ST_HIT             = 3'd1;
    localparam logic [2:0] ST_STORED_EMPTY    = 3'd2;
    localparam logic [2:0] ST_STORED_REPLACED = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE       = 3'd4;
    localparam logic [2:0] ST_DONE            = 3'd5;

    // Configuration register indexes
    localparam logic CFG_TTL    = 1'b0;
    localparam logic CFG_MAXLEN = 1'b1;

    // Command beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_tag;
        logic [31:0] response_handle;
        logic [23:0] response_length;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] hit_handle;
        logic [23:0] hit_length;
        logic        evicted_valid;
        logic [31:0] evicted_handle;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic [63:0] tag;
        logic [31:0] handle;
        logic [23:0] length;
        logic [31:0] saved_at;
    } entry_t;

    // Flags from the shared compare unit
    typedef struct packed {
        logic expired;
        logic tag_eq;
        logic older;
    } cmp_t;

endpackage

FILE: rtl/ttlc_entry_mem.sv
// Entry storage: one write port, one registered read port.
module ttlc_entry_mem #(
    parameter int unsigned ENTRIES = ttlc_pkg::ENTRIES_DEF,
    parameter int unsigned IDX_W   = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  ttlc_pkg::entry_t     wdata,
    input  logic [IDX_W-1:0]     raddr,
    output ttlc_pkg::entry_t     rdata
);

    ttlc_pkg::entry_t mem [ENTRIES];
    ttlc_pkg::entry_t rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry per cycle
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ttlc_cmp_unit.sv
// Shared compare unit: entry age against TTL, tag match, and saved-time ordering.
module ttlc_cmp_unit (
    input  logic [31:0]      now_sec,
    input  logic [31:0]      ttl,
    input  logic [63:0]      key_tag,
    input  logic [31:0]      best_saved,
    input  ttlc_pkg::entry_t ent,
    output ttlc_pkg::cmp_t   res
);

    logic [31:0] age;

    // Age wraps modulo 2^32, although the seconds counter itself saturates
    assign age         = now_sec - ent.saved_at;
    assign res.expired = (age > ttl);
    assign res.tag_eq  = (ent.tag == key_tag);
    assign res.older   = (ent.saved_at < best_saved);

endmodule

FILE: rtl/ttl_cache_tag_table_core.sv
// Top level: command sequencer, valid bits, seconds counter and configuration registers.
//
// TTL cache tag table. A command beat is taken when start is high and busy is low;
// exactly one result beat follows, shown on rsp for one cycle with done high, and the
// receiver cannot hold it off. Clear, tick and an oversize save are handled in the idle
// state and their result appears in the next cycle. Lookup and save walk the table one
// entry per cycle through the single read port of the entry memory: a lookup ends early
// on a hit, a save on a free slot, and a save that replaces scans every entry before its
// write. Configuration writes are always ready and should be issued only while busy is
// low and no result is pending.
module ttl_cache_tag_table_core #(
    parameter int unsigned ENTRIES = ttlc_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ttlc_pkg::req_t req,
    output logic           done,
    output ttlc_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam int unsigned      IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]         state_reg, state_next;
    ttlc_pkg::req_t     req_reg, req_next;
    ttlc_pkg::rsp_t     rsp_reg, rsp_next;
    logic               done_reg, done_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]        now_reg, now_next;
    logic [31:0]        ttl_reg;
    logic [23:0]        maxlen_reg;
    logic [IDX_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               cmp_live_reg, cmp_live_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [31:0]        best_saved_reg, best_saved_next;
    logic [31:0]        best_handle_reg, best_handle_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;

    ttlc_pkg::entry_t   rd_ent;
    ttlc_pkg::entry_t   wr_ent;
    ttlc_pkg::cmp_t     cmp_res;
    logic               mem_we;
    logic               take_best;
    logic [IDX_W+3:0]   cmp_idx_ext;
    logic [IDX_W+3:0]   wr_idx_ext;

    assign cmp_idx_ext = {4'b0000, cmp_idx_reg};
    assign wr_idx_ext  = {4'b0000, wr_idx_reg};

    // Entry storage, read at the issue pointer every cycle
    ttlc_entry_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_idx_reg),
        .wdata (wr_ent),
        .raddr (issue_idx_reg),
        .rdata (rd_ent)
    );

    // Shared compare on the entry that just came out of memory
    ttlc_cmp_unit u_cmp (
        .now_sec    (now_reg),
        .ttl        (ttl_reg),
        .key_tag    (req_reg.key_tag),
        .best_saved (best_saved_reg),
        .ent        (rd_ent),
        .res        (cmp_res)
    );

    assign wr_ent.tag      = req_reg.key_tag;
    assign wr_ent.handle   = req_reg.response_handle;
    assign wr_ent.length   = req_reg.response_length;
    assign wr_ent.saved_at = now_reg;

    assign take_best = (cmp_idx_reg == '0) || cmp_res.older;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        rsp_next         = rsp_reg;
        done_next        = 1'b0;
        valid_next       = valid_reg;
        now_next         = now_reg;
        issue_idx_next   = issue_idx_reg;
        issue_done_next  = issue_done_reg;
        cmp_live_next    = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        best_idx_next    = best_idx_reg;
        best_saved_next  = best_saved_reg;
        best_handle_next = best_handle_reg;
        found_next       = found_reg;
        wr_idx_next      = wr_idx_reg;
        mem_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = req;
                    rsp_next        = '0;
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                    best_idx_next   = '0;
                    found_next      = 1'b0;
                    case (req.cmd)
                        ttlc_pkg::CMD_LOOKUP:
                        begin
                            state_next = S_SCAN;
                        end
                        ttlc_pkg::CMD_SAVE:
                        begin
                            if (req.response_length > maxlen_reg)
                            begin
                                rsp_next.status = ttlc_pkg::ST_TOO_LARGE;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ttlc_pkg::CMD_CLEAR:
                        begin
                            valid_next      = '0;
                            rsp_next.status = ttlc_pkg::ST_DONE;
                            done_next       = 1'b1;
                        end
                        default:
                        begin
                            // tick: saturate the seconds counter
                            if (now_reg != 32'hFFFF_FFFF)
                            begin
                                now_next = now_reg + 32'd1;
                            end
                            rsp_next.status = ttlc_pkg::ST_DONE;
                            done_next       = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Advance the read pointer
                cmp_live_next = !issue_done_reg;
                cmp_idx_next  = issue_idx_reg;
                if (!issue_done_reg)
                begin
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                    end
                end

                // Check the entry read last cycle
                if (cmp_live_reg)
                begin
                    if (req_reg.cmd == ttlc_pkg::CMD_LOOKUP)
                    begin
                        if (valid_reg[cmp_idx_reg] && cmp_res.expired)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                        end
                        if (valid_reg[cmp_idx_reg] && !cmp_res.expired && cmp_res.tag_eq)
                        begin
                            rsp_next.status     = ttlc_pkg::ST_HIT;
                            rsp_next.slot       = cmp_idx_ext[3:0];
                            rsp_next.hit_handle = rd_ent.handle;
                            rsp_next.hit_length = rd_ent.length;
                            done_next           = 1'b1;
                            state_next          = S_IDLE;
                        end
                        else if (cmp_idx_reg == LAST_IDX)
                        begin
                            rsp_next.status = ttlc_pkg::ST_MISS;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        if (!valid_reg[cmp_idx_reg])
                        begin
                            // Free slot: take it
                            found_next  = 1'b1;
                            wr_idx_next = cmp_idx_reg;
                            state_next  = S_WRITE;
                        end
                        else
                        begin
                            // Track the oldest slot, lowest index on ties
                            if (take_best)
                            begin
                                best_idx_next    = cmp_idx_reg;
                                best_saved_next  = rd_ent.saved_at;
                                best_handle_next = rd_ent.handle;
                            end
                            if (cmp_idx_reg == LAST_IDX)
                            begin
                                wr_idx_next = take_best ? cmp_idx_reg : best_idx_reg;
                                state_next  = S_WRITE;
                            end
                        end
                    end
                end
            end

            S_WRITE:
            begin
                mem_we                 = 1'b1;
                valid_next[wr_idx_reg] = 1'b1;
                rsp_next.status        = found_reg ? ttlc_pkg::ST_STORED_EMPTY
                                                   : ttlc_pkg::ST_STORED_REPLACED;
                rsp_next.slot           = wr_idx_ext[3:0];
                rsp_next.evicted_valid  = !found_reg;
                rsp_next.evicted_handle = found_reg ? 32'd0 : best_handle_reg;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            valid_reg      <= '0;
            now_reg        <= '0;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b0;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            valid_reg      <= valid_next;
            now_reg        <= now_next;
            issue_idx_reg  <= issue_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_live_reg   <= cmp_live_next;
            found_reg      <= found_next;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        rsp_reg         <= rsp_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_saved_reg  <= best_saved_next;
        best_handle_reg <= best_handle_next;
        wr_idx_reg      <= wr_idx_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg    <= ttlc_pkg::TTL_RESET;
            maxlen_reg <= ttlc_pkg::MAXLEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ttlc_pkg::CFG_TTL:    ttl_reg    <= cfg_data;
                ttlc_pkg::CFG_MAXLEN: maxlen_reg <= cfg_data[23:0];
                default:              ttl_reg    <= ttl_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: verif/ttl_cache_tag_table_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the TTL cache tag table core: directed and random command beats.
module ttl_cache_tag_table_core_test;

    localparam int unsigned DEPTH         = ttlc_pkg::ENTRIES_DEF;
    localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    ttlc_pkg::req_t   req;
    logic             done;
    ttlc_pkg::rsp_t   rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [31:0]      cfg_data;

    // Mirror of the table, the seconds counter and the registers
    logic        ent_valid  [DEPTH];
    logic [63:0] ent_tag    [DEPTH];
    logic [31:0] ent_handle [DEPTH];
    logic [23:0] ent_length [DEPTH];
    logic [31:0] ent_saved  [DEPTH];
    logic [31:0] now_sec;
    logic [31:0] ttl_sec;
    logic [23:0] max_len;

    ttlc_pkg::rsp_t owed_rsp [$];
    logic [63:0]    tag_pool [8];
    int unsigned    mismatches      = 0;
    int unsigned    cycle_count     = 0;
    int unsigned    sender_idle_pct = 0;

    ttl_cache_tag_table_core #(.ENTRIES(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Apply one command to the mirror and return the result it causes
    function automatic ttlc_pkg::rsp_t apply_cache_cmd(input ttlc_pkg::req_t r);
        ttlc_pkg::rsp_t o;
        int unsigned    pos;
        logic           found;
        logic [31:0]    age;
        o     = '0;
        pos   = 0;
        found = 1'b0;
        case (r.cmd)
            ttlc_pkg::CMD_LOOKUP:
            begin
                // Scan in order, expiring stale entries until the first live match
                o.status = ttlc_pkg::ST_MISS;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (ent_valid[i] && !found)
                    begin
                        age = now_sec - ent_saved[i];
                        if (age > ttl_sec)
                            ent_valid[i] = 1'b0;
                        else if (ent_tag[i] == r.key_tag)
                        begin
                            found        = 1'b1;
                            o.status     = ttlc_pkg::ST_HIT;
                            o.slot       = 4'(i);
                            o.hit_handle = ent_handle[i];
                            o.hit_length = ent_length[i];
                        end
                    end
                end
            end
            ttlc_pkg::CMD_SAVE:
            begin
                if (r.response_length > max_len)
                    o.status = ttlc_pkg::ST_TOO_LARGE;
                else
                begin
                    // Take the first free slot, else the oldest, lowest index on ties
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!found && !ent_valid[i])
                        begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    if (found)
                        o.status = ttlc_pkg::ST_STORED_EMPTY;
                    else
                    begin
                        pos = 0;
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            if (ent_saved[i] < ent_saved[pos])
                                pos = i;
                        end
                        o.status         = ttlc_pkg::ST_STORED_REPLACED;
                        o.evicted_valid  = 1'b1;
                        o.evicted_handle = ent_handle[pos];
                    end
                    ent_tag[pos]    = r.key_tag;
                    ent_handle[pos] = r.response_handle;
                    ent_length[pos] = r.response_length;
                    ent_saved[pos]  = now_sec;
                    ent_valid[pos]  = 1'b1;
                    o.slot          = 4'(pos);
                end
            end
            ttlc_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    ent_valid[i] = 1'b0;
                o.status = ttlc_pkg::ST_DONE;
            end
            default:
            begin
                // Saturate the seconds counter
                if (now_sec != 32'hFFFF_FFFF)
                    now_sec = now_sec + 32'd1;
                o.status = ttlc_pkg::ST_DONE;
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // Compare each result beat with the oldest owed result
    always @(posedge clk)
    begin : result_check
        ttlc_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (owed_rsp.size() == 0)
                report_mismatch("result beat with no command outstanding");
            else
            begin
                want = owed_rsp.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("slot", want.slot, rsp.slot);
                check_field("hit_handle", want.hit_handle, rsp.hit_handle);
                check_field("hit_length", want.hit_length, rsp.hit_length);
                check_field("evicted_valid", want.evicted_valid, rsp.evicted_valid);
                check_field("evicted_handle", want.evicted_handle, rsp.evicted_handle);
            end
        end
    end

    function automatic ttlc_pkg::req_t make_req(input logic [1:0] cmd,
                                                input logic [63:0] tag,
                                                input logic [31:0] handle,
                                                input logic [23:0] length);
        ttlc_pkg::req_t r;
        r.cmd             = cmd;
        r.key_tag         = tag;
        r.response_handle = handle;
        r.response_length = length;
        return r;
    endfunction

    // Send one command beat; start stays high until a gap or a pause lowers it
    task automatic send_cmd(input ttlc_pkg::req_t r);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        owed_rsp.push_back(apply_cache_cmd(r));
    endtask

    // Hold off commands until every owed result is back and the core is quiet
    task automatic settle();
        start <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while idle
    task automatic write_config(input logic [31:0] ttl, input logic [23:0] maxlen);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= ttlc_pkg::CFG_TTL;
        cfg_data  <= ttl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ttl_sec    = ttl;
        cfg_index <= ttlc_pkg::CFG_MAXLEN;
        cfg_data  <= {8'($urandom), maxlen};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_len    = maxlen;
        cfg_valid <= 1'b0;
    endtask

    // Empty table, exact length limit and one past it, hit, clear
    task automatic test_limits_at_reset();
        send_cmd(make_req(ttlc_pkg::CMD_LOOKUP, 64'd0, 32'd0, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_SAVE, '1, '1, ttlc_pkg::MAXLEN_RESET));
        send_cmd(make_req(ttlc_pkg::CMD_SAVE, 64'd7, 32'd7,
                          ttlc_pkg::MAXLEN_RESET + 24'd1));
        send_cmd(make_req(ttlc_pkg::CMD_LOOKUP, '1, 32'd0, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_CLEAR, '1, '1, '1));
    endtask

    // Age an entry past a one-second lifetime and let a lookup drop it
    task automatic test_expiry();
        write_config(32'd1, 24'hFF_FFFF);
        send_cmd(make_req(ttlc_pkg::CMD_SAVE, 64'd0, 32'd0, 24'hFF_FFFF));
        send_cmd(make_req(ttlc_pkg::CMD_TICK, 64'd0, 32'd0, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_TICK, 64'd0, 32'd0, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_SAVE, 64'd5, 32'h5555_0005, 24'd12));
        send_cmd(make_req(ttlc_pkg::CMD_LOOKUP, 64'd5, 32'd0, 24'd0));
    endtask

    // Fill every slot at one time, then evict the oldest, lowest index first
    task automatic test_replace_oldest();
        write_config(32'hFFFF_FFFF, 24'd0);
        send_cmd(make_req(ttlc_pkg::CMD_CLEAR, 64'd0, 32'd0, 24'd0));
        for (int i = 0; i < DEPTH; i++)
            send_cmd(make_req(ttlc_pkg::CMD_SAVE, 64'(i) << 56, $urandom, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_TICK, 64'd0, 32'd0, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_SAVE, 64'hABCD, $urandom, 24'd0));
        send_cmd(make_req(ttlc_pkg::CMD_SAVE, 64'hBCDE, $urandom, 24'd0));
    endtask

    function automatic logic [23:0] pick_length();
        case ($urandom_range(4, 0))
            0:       return 24'($urandom_range(max_len, 0));
            1:       return max_len;
            2:       return max_len + 24'd1;
            3:       return 24'($urandom);
            default: return 24'($urandom_range(15, 0));
        endcase
    endfunction

    function automatic ttlc_pkg::req_t random_req();
        ttlc_pkg::req_t r;
        int unsigned    pick;
        pick              = $urandom_range(99, 0);
        r.cmd             = (pick < 40) ? ttlc_pkg::CMD_LOOKUP :
                            (pick < 78) ? ttlc_pkg::CMD_SAVE :
                            (pick < 98) ? ttlc_pkg::CMD_TICK : ttlc_pkg::CMD_CLEAR;
        // Mostly reuse a small tag set so lookups hit
        r.key_tag         = ($urandom_range(3, 0) != 0) ? tag_pool[$urandom_range(7, 0)]
                                                        : {$urandom, $urandom};
        r.response_handle = $urandom;
        r.response_length = pick_length();
        return r;
    endfunction

    // Random command mix under one setting and one idle pattern
    task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                               input logic [31:0] ttl, input logic [23:0] maxlen);
        write_config(ttl, maxlen);
        for (int i = 0; i < 8; i++)
            tag_pool[i] = {$urandom, $urandom};
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            send_cmd(random_req());
            // Now and then pause until every result is back
            if ($urandom_range(39, 0) == 0)
                settle();
        end
        sender_idle_pct = 0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ttlc_pkg::CFG_TTL;
        cfg_data  <= '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_valid[i]  = 1'b0;
            ent_tag[i]    = '0;
            ent_handle[i] = '0;
            ent_length[i] = '0;
            ent_saved[i]  = '0;
        end
        now_sec = '0;
        ttl_sec = ttlc_pkg::TTL_RESET;
        max_len = ttlc_pkg::MAXLEN_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_limits_at_reset();
        test_expiry();
        test_replace_oldest();
        test_random(220, 0, 32'd3, 24'd1000);
        test_random(220, 82, 32'd0, 24'hFF_FFFF);
        test_random(220, 0, 32'hFFFF_FFFF, 24'd0);
        test_random(240, 35, 32'd20, ttlc_pkg::MAXLEN_RESET);

        settle();
        if (mismatches == 0 && owed_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
